// ===== design/led_cube_frame_buffer_scan_assert.svh =====
// Assertion macros used by the checker file of the frame buffer scan block.
`ifndef LED_CUBE_FRAME_BUFFER_SCAN_ASSERT_SVH
`define LED_CUBE_FRAME_BUFFER_SCAN_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LCFB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LCFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lcfb_pkg.sv =====
package lcfb_pkg;

   localparam int CFG_W         = 4;
   localparam int COORD_W       = 3;
   localparam int BYTE_W        = 8;
   localparam int LAYER_OUT_W   = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 4;
   localparam logic [CFG_W-1:0] CFG_RESET_DIM = 4'd8;

   typedef enum logic [1:0] {
      OP_SET       = 2'd0,
      OP_CLEAR     = 2'd1,
      OP_CLEAR_ALL = 2'd2,
      OP_TICK      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_DEPTH  = 2'd1,
      CSR_HEIGHT = 2'd2,
      CSR_ANODES = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] depth;
      logic [CFG_W-1:0] height;
      logic [CFG_W-1:0] anodes;
   } cfg_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_INIT_ZERO,
      DP_CAPTURE,
      DP_MUL1,
      DP_MUL2,
      DP_VOX_READ,
      DP_VOX_WRITE,
      DP_SWEEP_READ,
      DP_SWEEP_WRITE,
      DP_LAYER,
      DP_BASE,
      DP_SEL_LOAD,
      DP_ANODE_READ,
      DP_ANODE_LOAD
   } dp_op_type;

   typedef struct packed {
      logic out_free;
      logic vox_ok;
      logic cnt_last;
      logic anode_last;
   } dp_status_type;

endpackage

// ===== design/led_cube_frame_buffer_scan.sv =====
// Channel   Direction  Handshake          Carries
// req_      in         valid / stall      opcode, x/y/z coordinate
// rsp_      out        valid / stall      chain, byte, latch, layer, last
// csr_      in         APB write / read   cube width, depth, height, anode bytes
//
// After reset the store is zeroed byte by byte; req_stall stays high until that is done.
// Set or clear voxel: accept, two multiply steps, read, write; no write when dropped.
// Clear all: accept, two multiply steps, then one read-modify-write of the store per byte.
// Refresh tick: accept, layer, base, select byte, then a registered store read and a load
// per anode byte; the select and each load wait while the result register is stalled.
// An item is accepted while the last result of the previous one still waits in rsp_.
module led_cube_frame_buffer_scan #(
   parameter int MAX_DIM     = 8,
   parameter int FRAME_BYTES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_opcode,
   input  logic [2:0]   req_x_coord,
   input  logic [2:0]   req_y_coord,
   input  logic [2:0]   req_z_coord,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_chain_select,
   output logic [7:0]   rsp_shift_byte,
   output logic         rsp_latch_now,
   output logic [2:0]   rsp_active_layer,
   output logic         rsp_last,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import lcfb_pkg::*;

   cfg_type       cfg;
   dp_op_type     dp_op;
   dp_status_type status;

   assign csr_pready = 1'b1;

   lcfb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   lcfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .status     (status),
      .dp_op      (dp_op)
   );

   lcfb_dp #(
      .MAX_DIM     (MAX_DIM),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .dp_op            (dp_op),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_z_coord      (req_z_coord),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_chain_select (rsp_chain_select),
      .rsp_shift_byte   (rsp_shift_byte),
      .rsp_latch_now    (rsp_latch_now),
      .rsp_active_layer (rsp_active_layer),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== design/lcfb_csr.sv =====
module lcfb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lcfb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lcfb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lcfb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output lcfb_pkg::cfg_type                   cfg
);
   import lcfb_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index = csr_index_type'(csr_paddr[3:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CSR_WIDTH:  cfg_in.width  = csr_pwdata[CFG_W-1:0];
            CSR_DEPTH:  cfg_in.depth  = csr_pwdata[CFG_W-1:0];
            CSR_HEIGHT: cfg_in.height = csr_pwdata[CFG_W-1:0];
            CSR_ANODES: cfg_in.anodes = csr_pwdata[CFG_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.width);
         CSR_DEPTH:  csr_prdata = CSR_DATA_W'(cfg_ff.depth);
         CSR_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.height);
         CSR_ANODES: csr_prdata = CSR_DATA_W'(cfg_ff.anodes);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{CFG_RESET_DIM, CFG_RESET_DIM, CFG_RESET_DIM, CFG_RESET_DIM};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/lcfb_ctrl.sv =====
module lcfb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_opcode,
   output logic                    req_stall,
   input  lcfb_pkg::dp_status_type status,
   output lcfb_pkg::dp_op_type     dp_op
);
   import lcfb_pkg::*;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_VOX_MUL1,
      ST_VOX_MUL2,
      ST_VOX_READ,
      ST_VOX_WRITE,
      ST_CLR_MUL1,
      ST_CLR_MUL2,
      ST_CLR_READ,
      ST_CLR_WRITE,
      ST_TICK_LAYER,
      ST_TICK_BASE,
      ST_TICK_SEL,
      ST_TICK_READ,
      ST_TICK_LOAD
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      dp_op    = DP_NOP;
      case (state_ff)
         ST_INIT: begin
            dp_op = DP_INIT_ZERO;
            if (status.cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               dp_op = DP_CAPTURE;
               case (op_type'(req_opcode))
                  OP_SET:       state_in = ST_VOX_MUL1;
                  OP_CLEAR:     state_in = ST_VOX_MUL1;
                  OP_CLEAR_ALL: state_in = ST_CLR_MUL1;
                  OP_TICK:      state_in = ST_TICK_LAYER;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_VOX_MUL1: begin
            dp_op    = DP_MUL1;
            state_in = ST_VOX_MUL2;
         end
         ST_VOX_MUL2: begin
            dp_op    = DP_MUL2;
            state_in = ST_VOX_READ;
         end
         ST_VOX_READ: begin
            // drop the item when the voxel lies outside the cube or the store
            if (status.vox_ok) begin
               dp_op    = DP_VOX_READ;
               state_in = ST_VOX_WRITE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_VOX_WRITE: begin
            dp_op    = DP_VOX_WRITE;
            state_in = ST_IDLE;
         end
         ST_CLR_MUL1: begin
            dp_op    = DP_MUL1;
            state_in = ST_CLR_MUL2;
         end
         ST_CLR_MUL2: begin
            dp_op    = DP_MUL2;
            state_in = ST_CLR_READ;
         end
         ST_CLR_READ: begin
            dp_op    = DP_SWEEP_READ;
            state_in = ST_CLR_WRITE;
         end
         ST_CLR_WRITE: begin
            dp_op    = DP_SWEEP_WRITE;
            state_in = status.cnt_last ? ST_IDLE : ST_CLR_READ;
         end
         ST_TICK_LAYER: begin
            dp_op    = DP_LAYER;
            state_in = ST_TICK_BASE;
         end
         ST_TICK_BASE: begin
            dp_op    = DP_BASE;
            state_in = ST_TICK_SEL;
         end
         ST_TICK_SEL: begin
            // hold until the result register can take the select byte
            if (status.out_free) begin
               dp_op    = DP_SEL_LOAD;
               state_in = ST_TICK_READ;
            end
         end
         ST_TICK_READ: begin
            dp_op    = DP_ANODE_READ;
            state_in = ST_TICK_LOAD;
         end
         ST_TICK_LOAD: begin
            if (status.out_free) begin
               dp_op    = DP_ANODE_LOAD;
               state_in = status.anode_last ? ST_IDLE : ST_TICK_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== design/lcfb_dp.sv =====
module lcfb_dp #(
   parameter int MAX_DIM     = 8,
   parameter int FRAME_BYTES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lcfb_pkg::cfg_type                 cfg,
   input  lcfb_pkg::dp_op_type               dp_op,
   output lcfb_pkg::dp_status_type           status,
   input  logic [1:0]                        req_opcode,
   input  logic [lcfb_pkg::COORD_W-1:0]      req_x_coord,
   input  logic [lcfb_pkg::COORD_W-1:0]      req_y_coord,
   input  logic [lcfb_pkg::COORD_W-1:0]      req_z_coord,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_chain_select,
   output logic [lcfb_pkg::BYTE_W-1:0]       rsp_shift_byte,
   output logic                              rsp_latch_now,
   output logic [lcfb_pkg::LAYER_OUT_W-1:0]  rsp_active_layer,
   output logic                              rsp_last
);
   import lcfb_pkg::*;

   localparam int DW  = $clog2(MAX_DIM + 1);
   localparam int LW  = $clog2(MAX_DIM);
   localparam int AW  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int NW  = 3 * DW + 3;
   localparam int CW  = ((NW > AW + 3) ? NW : AW + 3) + 1;
   localparam int IW  = LW + DW;
   localparam int LXW = LW + 4;

   // effective configuration
   logic [DW-1:0] w_eff;
   logic [DW-1:0] d_eff;
   logic [DW-1:0] h_eff;
   logic [DW-1:0] a_eff;

   assign w_eff = (cfg.width  > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg.width);
   assign d_eff = (cfg.depth  > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg.depth);
   assign h_eff = (cfg.height > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg.height);
   assign a_eff = (cfg.anodes == '0) ? DW'(1) :
                  ((cfg.anodes > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg.anodes));

   // item and working registers
   op_type              op_ff;
   logic [COORD_W-1:0]  x_ff, y_ff, z_ff;
   logic [2*DW-1:0]     wd_ff;
   logic [DW+2:0]       yw_ff;
   logic [NW-1:0]       bitno_ff;
   logic [NW-1:0]       nvox_ff;
   logic [AW-1:0]       cnt_ff;
   logic [LW-1:0]       layer_ff;
   logic [IW-1:0]       idx_ff;
   logic [DW-1:0]       aidx_ff;
   logic                beyond_ff;
   logic [BYTE_W-1:0]   rdata_ff;
   logic [BYTE_W-1:0]   voxel_ff [FRAME_BYTES];

   logic                rsp_valid_ff;
   logic                chain_ff;
   logic [BYTE_W-1:0]   byte_ff;
   logic                latch_ff;
   logic [LAYER_OUT_W-1:0] layer_out_ff;
   logic                last_ff;

   // next values
   logic [2*DW-1:0]     wd_in;
   logic [DW+2:0]       yw_in;
   logic [NW-1:0]       bitno_in;
   logic [NW-1:0]       nvox_in;
   logic [LW:0]         layer_inc;
   logic [LW-1:0]       layer_in;
   logic [IW-1:0]       base_in;

   // memory port
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [BYTE_W-1:0]   mem_wdata;
   logic                mem_re;
   logic [AW-1:0]       mem_raddr;

   logic                coords_in;
   logic [AW-1:0]       vox_addr;
   logic [BYTE_W-1:0]   vox_mask;
   logic [BYTE_W-1:0]   vox_wdata;
   logic [CW-1:0]       sweep_base;
   logic [BYTE_W-1:0]   keep_mask;
   logic                idx_beyond;
   logic [LXW-1:0]      layer_x;
   logic [BYTE_W-1:0]   sel_byte;
   logic                out_free;
   logic                anode_last;
   logic                out_load;

   assign wd_in    = (2*DW)'(w_eff) * (2*DW)'(d_eff);
   assign yw_in    = (DW+3)'(y_ff) * (DW+3)'(w_eff);
   assign bitno_in = NW'(z_ff) * NW'(wd_ff) + NW'(yw_ff) + NW'(x_ff);
   assign nvox_in  = NW'(wd_ff) * NW'(h_eff);

   assign layer_inc = (LW+1)'(layer_ff) + (LW+1)'(1);
   assign layer_in  = (layer_inc >= (LW+1)'(h_eff)) ? '0 : layer_inc[LW-1:0];
   assign base_in   = IW'(layer_ff) * IW'(a_eff);

   assign coords_in = (8'(x_ff) < 8'(w_eff)) && (8'(y_ff) < 8'(d_eff)) &&
                      (8'(z_ff) < 8'(h_eff));
   assign vox_addr  = AW'(bitno_ff >> 3);
   assign vox_mask  = BYTE_W'(1) << bitno_ff[2:0];
   assign vox_wdata = (op_ff == OP_SET) ? (rdata_ff | vox_mask) : (rdata_ff & ~vox_mask);

   // keep every bit at or beyond the voxel count
   assign sweep_base = CW'({cnt_ff, 3'b000});
   always_comb begin
      for (int k = 0; k < BYTE_W; k++) begin
         keep_mask[k] = (sweep_base + CW'(k)) >= CW'(nvox_ff);
      end
   end

   assign idx_beyond = (32'(idx_ff) >= FRAME_BYTES);

   assign layer_x = LXW'(layer_ff);
   always_comb begin
      for (int k = 0; k < BYTE_W; k++) begin
         sel_byte[k] = (layer_x == LXW'(k));
      end
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign anode_last = ((DW+1)'(aidx_ff) + (DW+1)'(1)) == (DW+1)'(a_eff);
   assign out_load   = (dp_op == DP_SEL_LOAD) || (dp_op == DP_ANODE_LOAD);

   assign status.out_free   = out_free;
   assign status.vox_ok     = coords_in && (32'(bitno_ff >> 3) < FRAME_BYTES);
   assign status.cnt_last   = (cnt_ff == AW'(FRAME_BYTES - 1));
   assign status.anode_last = anode_last;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = cnt_ff;
      case (dp_op)
         DP_INIT_ZERO: begin
            mem_we = 1'b1;
         end
         DP_VOX_READ: begin
            mem_re    = 1'b1;
            mem_raddr = vox_addr;
         end
         DP_VOX_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = vox_addr;
            mem_wdata = vox_wdata;
         end
         DP_SWEEP_READ: begin
            mem_re = 1'b1;
         end
         DP_SWEEP_WRITE: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_ff & keep_mask;
         end
         DP_ANODE_READ: begin
            mem_re    = !idx_beyond;
            mem_raddr = AW'(idx_ff);
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         voxel_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= voxel_ff[mem_raddr];
      end
   end

   // control counters and layer
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         layer_ff <= '0;
      end else begin
         case (dp_op)
            DP_INIT_ZERO:   cnt_ff   <= cnt_ff + AW'(1);
            DP_CAPTURE:     cnt_ff   <= '0;
            DP_SWEEP_WRITE: cnt_ff   <= cnt_ff + AW'(1);
            DP_LAYER:       layer_ff <= layer_in;
            default:        cnt_ff   <= cnt_ff;
         endcase
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      case (dp_op)
         DP_CAPTURE: begin
            op_ff <= op_type'(req_opcode);
            x_ff  <= req_x_coord;
            y_ff  <= req_y_coord;
            z_ff  <= req_z_coord;
         end
         DP_MUL1: begin
            wd_ff <= wd_in;
            yw_ff <= yw_in;
         end
         DP_MUL2: begin
            bitno_ff <= bitno_in;
            nvox_ff  <= nvox_in;
         end
         DP_BASE: begin
            idx_ff  <= base_in;
            aidx_ff <= '0;
         end
         DP_ANODE_READ: begin
            beyond_ff <= idx_beyond;
         end
         DP_ANODE_LOAD: begin
            idx_ff  <= idx_ff + IW'(1);
            aidx_ff <= aidx_ff + DW'(1);
         end
         default: op_ff <= op_ff;
      endcase
   end

   // result register: loads when empty or while the previous item is being taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_op == DP_SEL_LOAD) begin
         chain_ff     <= 1'b0;
         byte_ff      <= sel_byte;
         latch_ff     <= 1'b1;
         layer_out_ff <= layer_x[LAYER_OUT_W-1:0];
         last_ff      <= 1'b0;
      end else if (dp_op == DP_ANODE_LOAD) begin
         chain_ff     <= 1'b1;
         byte_ff      <= beyond_ff ? '0 : rdata_ff;
         latch_ff     <= anode_last;
         layer_out_ff <= layer_x[LAYER_OUT_W-1:0];
         last_ff      <= anode_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chain_select = chain_ff;
   assign rsp_shift_byte   = byte_ff;
   assign rsp_latch_now    = latch_ff;
   assign rsp_active_layer = layer_out_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== design/lcfb_checker.sv =====
`include "led_cube_frame_buffer_scan_assert.svh"

module lcfb_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_chain_select,
   input logic [7:0] rsp_shift_byte,
   input logic       rsp_latch_now,
   input logic       rsp_last
);

   // a stalled item holds its bytes
   `LCFB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_shift_byte) && $stable(rsp_last), "rsp item changed under stall")

   // the layer-select byte latches its own chain and never ends a tick
   `LCFB_ASSERT_IMPL(a_select_byte, clock, reset, rsp_valid && !rsp_chain_select, rsp_latch_now && !rsp_last && $onehot0(rsp_shift_byte), "bad layer-select item")

   // a tick ends on the anode chain
   `LCFB_ASSERT_IMPL(a_last_on_anode, clock, reset, rsp_valid && rsp_last, rsp_chain_select, "last item not on anode chain")

   // the anode chain latches only on its final byte
   `LCFB_ASSERT_IMPL(a_anode_latch, clock, reset, rsp_valid && rsp_chain_select, rsp_latch_now == rsp_last, "anode latch apart from last")

endmodule

bind led_cube_frame_buffer_scan lcfb_checker u_checker (.*);

// ===== tb/led_cube_frame_buffer_scan_checker.sv =====
module led_cube_frame_buffer_scan_checker #(
   parameter int MAX_DIM     = 8,
   parameter int FRAME_BYTES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  logic [1:0]   req_opcode,
   input  logic [2:0]   req_x_coord,
   input  logic [2:0]   req_y_coord,
   input  logic [2:0]   req_z_coord,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  logic         rsp_chain_select,
   input  logic [7:0]   rsp_shift_byte,
   input  logic         rsp_latch_now,
   input  logic [2:0]   rsp_active_layer,
   input  logic         rsp_last,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic [31:0]  csr_prdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           pending_beats
);
   timeunit 1ns;
   timeprecision 1ps;

   import lcfb_pkg::*;

   typedef struct packed {
      logic       chain_select;
      logic [7:0] shift_byte;
      logic       latch_now;
      logic [2:0] active_layer;
      logic       last;
   } scan_beat_type;

   cfg_type       cube_cfg;
   logic [7:0]    frame_bytes [FRAME_BYTES];
   int            layer_now;
   scan_beat_type scan_beats [$];

   function automatic int eff_dim(logic [CFG_W-1:0] d);
      return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
   endfunction

   function automatic void put_voxel(int x, int y, int z, logic on);
      int w, d, h, bitno, byte_at;
      w = eff_dim(cube_cfg.width);
      d = eff_dim(cube_cfg.depth);
      h = eff_dim(cube_cfg.height);
      if (x >= w || y >= d || z >= h) return;
      bitno   = z * w * d + y * w + x;
      byte_at = bitno / 8;
      if (byte_at >= FRAME_BYTES) return;
      frame_bytes[byte_at][bitno % 8] = on;
   endfunction

   // Advance the layer, then queue the select byte and the layer's anode bytes.
   function automatic void scan_layer();
      int h, a, i, idx;
      scan_beat_type beat;
      h = eff_dim(cube_cfg.height);
      a = eff_dim(cube_cfg.anodes);
      if (a == 0) a = 1;
      layer_now = layer_now + 1;
      if (layer_now >= h) layer_now = 0;
      beat.chain_select = 1'b0;
      beat.shift_byte   = (layer_now < 8) ? 8'(1 << layer_now) : 8'h00;
      beat.latch_now    = 1'b1;
      beat.active_layer = layer_now[2:0];
      beat.last         = 1'b0;
      scan_beats.push_back(beat);
      for (i = 0; i < a; i++) begin
         idx = layer_now * a + i;
         beat.chain_select = 1'b1;
         beat.shift_byte   = (idx < FRAME_BYTES) ? frame_bytes[idx] : 8'h00;
         beat.latch_now    = (i == a - 1);
         beat.last         = (i == a - 1);
         scan_beats.push_back(beat);
      end
   endfunction

   function automatic void apply_item(op_type op, int x, int y, int z);
      int i, j, k;
      case (op)
         OP_SET:   put_voxel(x, y, z, 1'b1);
         OP_CLEAR: put_voxel(x, y, z, 1'b0);
         OP_CLEAR_ALL: begin
            for (i = 0; i < MAX_DIM; i++)
               for (j = 0; j < MAX_DIM; j++)
                  for (k = 0; k < MAX_DIM; k++)
                     put_voxel(i, j, k, 1'b0);
         end
         OP_TICK:  scan_layer();
         default:  ;
      endcase
   endfunction

   function automatic logic [31:0] cfg_value(csr_index_type idx);
      case (idx)
         CSR_WIDTH:  return {28'd0, cube_cfg.width};
         CSR_DEPTH:  return {28'd0, cube_cfg.depth};
         CSR_HEIGHT: return {28'd0, cube_cfg.height};
         default:    return {28'd0, cube_cfg.anodes};
      endcase
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      scan_beat_type want;
      if (reset) begin
         fail_count = 0;
         cube_cfg  = {4{CFG_RESET_DIM}};
         layer_now = 0;
         for (int n = 0; n < FRAME_BYTES; n++) frame_bytes[n] = 8'h00;
         scan_beats.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_index_type'(csr_paddr[3:2]))
                  CSR_WIDTH:  cube_cfg.width  = csr_pwdata[3:0];
                  CSR_DEPTH:  cube_cfg.depth  = csr_pwdata[3:0];
                  CSR_HEIGHT: cube_cfg.height = csr_pwdata[3:0];
                  CSR_ANODES: cube_cfg.anodes = csr_pwdata[3:0];
                  default:    ;
               endcase
            end else begin
               check_field("csr_prdata", cfg_value(csr_index_type'(csr_paddr[3:2])),
                           csr_prdata);
            end
         end
         // Retire results before queueing new ones; the queue keeps them in order.
         if (rsp_valid && !rsp_stall) begin
            if (scan_beats.size() == 0) begin
               $error("result item with nothing expected: chain %0d byte 0x%0h",
                      rsp_chain_select, rsp_shift_byte);
               fail_count++;
            end else begin
               want = scan_beats.pop_front();
               check_field("chain_select", want.chain_select, rsp_chain_select);
               check_field("shift_byte", want.shift_byte, rsp_shift_byte);
               check_field("latch_now", want.latch_now, rsp_latch_now);
               check_field("active_layer", want.active_layer, rsp_active_layer);
               check_field("last", want.last, rsp_last);
            end
         end
         if (req_valid && !req_stall)
            apply_item(op_type'(req_opcode), req_x_coord, req_y_coord, req_z_coord);
      end
      pending_beats = scan_beats.size();
   end

endmodule

// ===== tb/led_cube_frame_buffer_scan_tb.sv =====
module led_cube_frame_buffer_scan_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lcfb_pkg::*;

   localparam int MAX_DIM      = 8;
   localparam int FRAME_BYTES  = 64;
   // Clear all is the slowest item: one read-modify-write per store byte.
   localparam int QUIET_CYCLES = 2 * FRAME_BYTES + 40;
   localparam int IDLE_LIMIT   = 3000;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = OP_SET;
   logic [2:0]  req_x_coord = '0;
   logic [2:0]  req_y_coord = '0;
   logic [2:0]  req_z_coord = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_chain_select;
   logic [7:0]  rsp_shift_byte;
   logic        rsp_latch_now;
   logic [2:0]  rsp_active_layer;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending_beats;

   int          cube_w = 8, cube_d = 8, cube_h = 8;
   int          stall_left = 0, open_left = 0, idle_cycles = 0;

   led_cube_frame_buffer_scan #(
      .MAX_DIM(MAX_DIM),
      .FRAME_BYTES(FRAME_BYTES)
   ) dut (.*);

   led_cube_frame_buffer_scan_checker #(
      .MAX_DIM(MAX_DIM),
      .FRAME_BYTES(FRAME_BYTES)
   ) scan_check (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic int pick_dim();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(9, 15);
      return $urandom_range(1, 8);
   endfunction

   // Stay inside the configured cube most of the time.
   function automatic logic [2:0] pick_coord(int dim);
      int lim;
      lim = (dim > MAX_DIM) ? MAX_DIM : dim;
      if (lim > 0 && $urandom_range(0, 4) != 0) return 3'($urandom_range(0, lim - 1));
      return 3'($urandom_range(0, 7));
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (open_left > 0) begin
            open_left--;
         end else begin
            open_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 6);
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $error("no item moved for %0d cycles", IDLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Called and returns just after a falling edge.
   task automatic push_item(op_type op, logic [2:0] x, logic [2:0] y, logic [2:0] z);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_x_coord <= x;
      req_y_coord <= y;
      req_z_coord <= z;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drop valid, wait for every result, then let a clear-all run out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_beats != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(logic wr, csr_index_type idx, logic [3:0] val);
      logic [31:0] junk;
      junk = $urandom();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {junk[31:4], val};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_reg(csr_index_type idx, int val);
      csr_access(1'b1, idx, 4'(val));
      csr_access(1'b0, idx, 4'd0);
   endtask

   task automatic set_cube(int w, int d, int h, int a);
      wait_drained();
      program_reg(CSR_WIDTH, w);
      program_reg(CSR_DEPTH, d);
      program_reg(CSR_HEIGHT, h);
      program_reg(CSR_ANODES, a);
      cube_w = w;
      cube_d = d;
      cube_h = h;
   endtask

   initial begin
      int r;
      op_type op;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Corners and wrap at the reset size.
      push_item(OP_SET, 0, 0, 0);
      push_item(OP_SET, 7, 7, 7);
      push_item(OP_SET, 7, 0, 0);
      push_item(OP_SET, 0, 7, 3);
      push_item(OP_CLEAR, 7, 0, 0);
      repeat (8) push_item(OP_TICK, 0, 0, 0);
      push_item(OP_CLEAR_ALL, 0, 0, 0);
      push_item(OP_TICK, 0, 0, 0);

      // Small cube: one coordinate out of range at a time.
      set_cube(3, 2, 3, 2);
      push_item(OP_SET, 3, 1, 1);
      push_item(OP_SET, 2, 2, 1);
      push_item(OP_SET, 2, 1, 3);
      push_item(OP_SET, 2, 1, 2);
      push_item(OP_SET, 0, 0, 0);
      repeat (3) push_item(OP_TICK, 0, 0, 0);

      // Zero dimensions hold the layer at 0; zero anode count acts as one.
      set_cube(0, 8, 0, 0);
      push_item(OP_SET, 0, 0, 0);
      push_item(OP_TICK, 0, 0, 0);

      // Oversized values saturate.
      set_cube(15, 15, 15, 15);
      push_item(OP_SET, 7, 7, 7);
      push_item(OP_TICK, 0, 0, 0);

      for (int p = 0; p < PHASES; p++) begin
         set_cube(pick_dim(), pick_dim(), pick_dim(), pick_dim());
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == PHASES / 2 && n == PHASE_ITEMS / 2) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 40)      op = OP_SET;
            else if (r < 60) op = OP_CLEAR;
            else if (r < 64) op = OP_CLEAR_ALL;
            else             op = OP_TICK;
            push_item(op, pick_coord(cube_w), pick_coord(cube_d), pick_coord(cube_h));
         end
      end

      wait_drained();
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
